### rtl/go_to_goal_velocity_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Go-to-goal controller assertion macros
// Clocked property wrappers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH

// property checked only outside reset
`define GGVC_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) prop) else $error("ggvc check failed");

// property checked during reset as well
`define GGVC_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge i_clk) \
    prop) else $error("ggvc reset check failed");

`endif

### rtl/ggvc_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Widths, constants, register indexes and shared helpers.
// ----------------------------------------------------------------------------
package ggvc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int XW = 36;   // CORDIC x/y datapath
    localparam int ZW = 20;   // CORDIC angle, Q.16

    localparam logic signed [ZW-1:0] PI_Q16     = 20'sd205887;
    localparam logic signed [16:0]   PI_Q12     = 17'sd12868;
    localparam logic signed [16:0]   NEG_PI_LO  = -17'sd12867;
    localparam logic signed [16:0]   TWO_PI_Q12 = 17'sd25736;
    localparam logic [14:0]          HALF_PI_Q12 = 15'd6434;
    localparam logic [21:0]          INV_GAIN_Q22 = 22'd2547003;
    localparam logic signed [32:0]   ONE_Q16    = 33'sd65536;
    localparam logic [31:0]          HALF_Q16   = 32'd32768;

    localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
        20'sd16, 20'sd8, 20'sd4, 20'sd2
    };

    typedef enum logic [2:0] {
        REG_GOAL_X          = 3'd0,
        REG_GOAL_Y          = 3'd1,
        REG_GOAL_HEADING    = 3'd2,
        REG_TURN_GAIN       = 3'd3,
        REG_SPEED_GAIN      = 3'd4,
        REG_DISTANCE_MARGIN = 3'd5,
        REG_HEADING_MARGIN  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [14:0] goal_heading;
        logic [15:0]        turn_gain;
        logic [15:0]        speed_gain;
        logic [30:0]        distance_margin;
        logic [13:0]        heading_margin;
        logic               goal_wr;
    } t_cfg;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [ZW-1:0] z;
        logic signed [14:0]   rh;
    } t_vec;

    // reduce an angle difference into -pi+1 .. pi (Q3.12); one fold suffices here
    function automatic logic signed [14:0] wrap_q12(input logic signed [16:0] d);
        logic signed [16:0] m;
        if (d > PI_Q12)
            m = d - TWO_PI_Q12;
        else if (d < NEG_PI_LO)
            m = d + TWO_PI_Q12;
        else
            m = d;
        return m[14:0];
    endfunction

endpackage

### rtl/ggvc_pose_if.sv
// ----------------------------------------------------------------------------
// Pose stream interface
// One robot pose sample per beat.
// ----------------------------------------------------------------------------
interface ggvc_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [14:0] robot_heading;

    modport source (output valid, robot_x, robot_y, robot_heading, input ready);
    modport sink   (input valid, robot_x, robot_y, robot_heading, output ready);
endinterface

### rtl/ggvc_cmd_if.sv
// ----------------------------------------------------------------------------
// Velocity command stream interface
// One velocity command per beat.
// ----------------------------------------------------------------------------
interface ggvc_cmd_if;
    logic               valid;
    logic               ready;
    logic [15:0]        forward_speed;
    logic signed [31:0] turn_rate;
    logic               goal_done;

    modport source (output valid, forward_speed, turn_rate, goal_done, input ready);
    modport sink   (input valid, forward_speed, turn_rate, goal_done, output ready);
endinterface

### rtl/ggvc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// One register write per beat.
// ----------------------------------------------------------------------------
interface ggvc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ggvc_cfg.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller register file
// Holds goal pose, gains and margins; flags goal writes.
// ----------------------------------------------------------------------------
module ggvc_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ggvc_cfg_if.sink        i_cfg,
    output ggvc_pkg::t_cfg  o_cfg
);

    ggvc_pkg::t_cfg r_cfg;
    logic           wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x          <= '0;
            r_cfg.goal_y          <= '0;
            r_cfg.goal_heading    <= '0;
            r_cfg.turn_gain       <= 16'd256;
            r_cfg.speed_gain      <= 16'd256;
            r_cfg.distance_margin <= 31'd6554;
            r_cfg.heading_margin  <= 14'd410;
            r_cfg.goal_wr         <= 1'b0;
        end else begin
            r_cfg.goal_wr <= 1'b0;
            if (wr) begin
                case (ggvc_pkg::t_reg_idx'(i_cfg.index))
                    ggvc_pkg::REG_GOAL_X: begin
                        r_cfg.goal_x  <= i_cfg.data;
                        r_cfg.goal_wr <= 1'b1;
                    end
                    ggvc_pkg::REG_GOAL_Y: begin
                        r_cfg.goal_y  <= i_cfg.data;
                        r_cfg.goal_wr <= 1'b1;
                    end
                    ggvc_pkg::REG_GOAL_HEADING: begin
                        r_cfg.goal_heading <= i_cfg.data[14:0];
                        r_cfg.goal_wr      <= 1'b1;
                    end
                    ggvc_pkg::REG_TURN_GAIN:       r_cfg.turn_gain <= i_cfg.data[15:0];
                    ggvc_pkg::REG_SPEED_GAIN:      r_cfg.speed_gain <= i_cfg.data[15:0];
                    ggvc_pkg::REG_DISTANCE_MARGIN: r_cfg.distance_margin <= i_cfg.data[30:0];
                    ggvc_pkg::REG_HEADING_MARGIN:  r_cfg.heading_margin <= i_cfg.data[13:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### rtl/ggvc_cordic.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller vectoring CORDIC
// Goal offset, half-plane fold, then one rotation per pipeline stage.
// ----------------------------------------------------------------------------
module ggvc_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [31:0]  i_robot_x,
    input  logic signed [31:0]  i_robot_y,
    input  logic signed [14:0]  i_robot_heading,
    input  ggvc_pkg::t_cfg      i_cfg,
    output ggvc_pkg::t_vec      o_vec
);

    localparam int N  = ggvc_pkg::CORDIC_STEPS;
    localparam int XW = ggvc_pkg::XW;
    localparam int ZW = ggvc_pkg::ZW;

    logic                 r_v  [N+1];
    logic signed [XW-1:0] r_x  [N+1];
    logic signed [XW-1:0] r_y  [N+1];
    logic signed [ZW-1:0] r_z  [N+1];
    logic signed [14:0]   r_rh [N+1];

    logic signed [32:0]   dx, dy;
    logic signed [XW-1:0] dxe, dye;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;

    always_comb begin
        dx  = $signed({i_cfg.goal_x[31], i_cfg.goal_x}) - $signed({i_robot_x[31], i_robot_x});
        dy  = $signed({i_cfg.goal_y[31], i_cfg.goal_y}) - $signed({i_robot_y[31], i_robot_y});
        dxe = {{(XW-33){dx[32]}}, dx};
        dye = {{(XW-33){dy[32]}}, dy};
        // fold the left half-plane onto the right, starting at +-pi
        if (dx < 0) begin
            n_x = -dxe;
            n_y = -dye;
            n_z = (dy >= 0) ? ggvc_pkg::PI_Q16 : -ggvc_pkg::PI_Q16;
        end else begin
            n_x = dxe;
            n_y = dye;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= n_x;
            r_y[0]  <= n_y;
            r_z[0]  <= n_z;
            r_rh[0] <= i_robot_heading;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        logic signed [XW-1:0] xs, ys;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rh[k+1] <= r_rh[k];
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + ggvc_pkg::ATAN_Q16[k];
                end else begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - ggvc_pkg::ATAN_Q16[k];
                end
            end
        end
    end

    assign o_vec.valid = r_v[N];
    assign o_vec.x     = r_x[N];
    assign o_vec.z     = r_z[N];
    assign o_vec.rh    = r_rh[N];

endmodule

### rtl/ggvc_post.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller control law
// Distance scaling, heading errors, gains, limits and the reached flag.
// ----------------------------------------------------------------------------
module ggvc_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ggvc_pkg::t_cfg  i_cfg,
    input  ggvc_pkg::t_vec  i_vec,
    output logic            o_en,
    ggvc_cmd_if.source      o_cmd
);

    localparam int ZW_B = ggvc_pkg::ZW;

    typedef enum logic [1:0] {
        M_DONE,
        M_FINAL,
        M_STEER,
        M_ROTATE
    } t_mode;

    // stage 1: partial products of the gain correction, bearing rounding
    logic               r_v1;
    logic [39:0]        r_plo;
    logic [38:0]        r_phi;
    logic signed [15:0] r_bearing;
    logic signed [14:0] r_rh1;
    // stage 2: distance and both wrapped errors
    logic               r_v2;
    logic [33:0]        r_dist;
    logic signed [14:0] r_eh, r_eb;
    // stage 3: mode and products
    logic               r_v3;
    t_mode              r_mode;
    logic signed [31:0] r_tprod;
    logic [38:0]        r_sprod;
    logic               r_ssat;
    logic               r_epos;
    // output register
    logic               r_ov;
    logic [15:0]        r_speed;
    logic signed [31:0] r_turn;
    logic               r_reached;

    logic [34:0]        xc;
    logic signed [ZW_B-1:0] zr;
    logic [56:0]        dsum;
    logic               near, hit, inhalf;
    logic signed [14:0] err;
    logic [14:0]        aerr;
    t_mode              n_mode;
    logic signed [32:0] tsum, tq;
    logic [39:0]        ssum;
    logic [31:0]        sq;
    logic [15:0]        n_speed;
    logic signed [31:0] n_turn;
    logic               n_reached;

    assign o_en = !r_ov || o_cmd.ready;

    always_comb begin
        xc   = i_vec.x[ggvc_pkg::XW-1] ? '0 : i_vec.x[34:0];
        zr   = i_vec.z + ZW_B'(8);
        dsum = {r_phi, 18'd0} + {17'd0, r_plo} + 57'd2097152;

        near   = r_dist <= {3'd0, i_cfg.distance_margin};
        err    = near ? r_eh : r_eb;
        aerr   = err[14] ? 15'(-err) : 15'(err);
        hit    = aerr <= {1'b0, i_cfg.heading_margin};
        inhalf = aerr <= ggvc_pkg::HALF_PI_Q12;
        if (near && hit)
            n_mode = M_DONE;
        else if (near)
            n_mode = M_FINAL;
        else if (inhalf)
            n_mode = M_STEER;
        else
            n_mode = M_ROTATE;

        tsum = $signed({r_tprod[31], r_tprod}) + 33'sd8;
        tq   = tsum >>> 4;
        ssum = {1'b0, r_sprod} + 40'd128;
        sq   = ssum[39:8];

        n_speed   = '0;
        n_turn    = '0;
        n_reached = r_reached;
        case (r_mode)
            M_DONE: n_reached = 1'b1;
            M_FINAL: n_turn = tq[31:0];
            M_STEER: begin
                if (tq > ggvc_pkg::ONE_Q16)
                    n_turn = 32'sd65536;
                else if (tq < -ggvc_pkg::ONE_Q16)
                    n_turn = -32'sd65536;
                else
                    n_turn = tq[31:0];
                if (r_ssat || sq > ggvc_pkg::HALF_Q16)
                    n_speed = 16'h8000;
                else
                    n_speed = sq[15:0];
            end
            M_ROTATE: n_turn = r_epos ? 32'sd65536 : -32'sd65536;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_ov      <= 1'b0;
            r_reached <= 1'b0;
        end else begin
            if (o_en) begin
                r_v1 <= i_vec.valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_ov <= r_v3;
            end
            // the user must write the goal only while idle; the block itself does not enforce it
            if (i_cfg.goal_wr)
                r_reached <= 1'b0;
            else if (o_en && r_v3)
                r_reached <= n_reached;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_plo     <= 40'(xc[17:0]) * 40'(ggvc_pkg::INV_GAIN_Q22);
            r_phi     <= 39'(xc[34:18]) * 39'(ggvc_pkg::INV_GAIN_Q22);
            r_bearing <= 16'(zr >>> 4);
            r_rh1     <= i_vec.rh;

            r_dist <= dsum[55:22];
            r_eh   <= ggvc_pkg::wrap_q12($signed({{2{i_cfg.goal_heading[14]}},
                                                  i_cfg.goal_heading})
                                         - $signed({{2{r_rh1[14]}}, r_rh1}));
            r_eb   <= ggvc_pkg::wrap_q12($signed({r_bearing[15], r_bearing})
                                         - $signed({{2{r_rh1[14]}}, r_rh1}));

            r_mode  <= n_mode;
            r_tprod <= $signed({1'b0, i_cfg.turn_gain}) * err;
            r_sprod <= 39'(i_cfg.speed_gain) * 39'(r_dist[22:0]);
            // any distance of 2^23 or more with a nonzero gain hits the cap
            r_ssat  <= (i_cfg.speed_gain != 16'd0) && (r_dist[33:23] != 11'd0);
            r_epos  <= err > 0;

            r_speed <= n_speed;
            r_turn  <= n_turn;
        end
    end

    assign o_cmd.valid         = r_ov;
    assign o_cmd.forward_speed = r_speed;
    assign o_cmd.turn_rate     = r_turn;
    assign o_cmd.goal_done     = r_reached;

endmodule

### rtl/go_to_goal_velocity_controller_unit.sv
// Pipeline: fold stage, 16 CORDIC stages, three control-law stages, output
//   register.
// Throughput: one pose per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// Reset: synchronous, active low; clears stage valid bits, the reached flag
//   and loads the register defaults. Config port is always ready.
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller
// Proportional unicycle controller toward a configured goal pose.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ggvc_cfg_if.sink    i_cfg,
    ggvc_pose_if.sink   i_pose,
    ggvc_cmd_if.source  o_cmd
);

    ggvc_pkg::t_cfg cfg;
    ggvc_pkg::t_vec vec;
    logic           en;

    assign i_pose.ready = en;

    ggvc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ggvc_cordic u_cordic (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_pose.valid),
        .i_robot_x       (i_pose.robot_x),
        .i_robot_y       (i_pose.robot_y),
        .i_robot_heading (i_pose.robot_heading),
        .i_cfg           (cfg),
        .o_vec           (vec)
    );

    ggvc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vec   (vec),
        .o_en    (en),
        .o_cmd   (o_cmd)
    );

endmodule

### rtl/ggvc_checker.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller port checker
// Watches the top-level channels over time.
// ----------------------------------------------------------------------------
`include "go_to_goal_velocity_controller_unit_defines.svh"

module ggvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_speed,
    input logic [31:0] i_turn
);

    `GGVC_ASSERT(a_speed_cap, i_out_valid |-> i_speed <= 16'd32768)
    `GGVC_ASSERT(a_drive_turn_sat, (i_out_valid && i_speed != 16'd0) |-> ($signed(i_turn) <= 32'sd65536 && $signed(i_turn) >= -32'sd65536))
    `GGVC_ASSERT(a_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_turn) && $stable(i_speed)))
    `GGVC_ASSERT(a_backpressure, (i_out_valid && !i_out_ready) |-> !i_in_ready)
    `GGVC_ASSERT_RST(a_reset_idle, !i_rst_n |=> !i_out_valid)

endmodule

bind go_to_goal_velocity_controller_unit ggvc_checker u_ggvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pose.ready),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_speed     (o_cmd.forward_speed),
    .i_turn      (o_cmd.turn_rate)
);

### verif/tb.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller testbench
// Streams pose beats through the controller under several goal, gain and
// margin settings. A behavioral copy of the control law predicts each
// velocity command, and a monitor compares every command beat in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int         DRAIN_CYCLES = 30;
    localparam longint     CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [15:0]        forward_speed;
        logic signed [31:0] turn_rate;
        logic               goal_done;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ggvc_cfg_if  cfg ();
    ggvc_pose_if pose ();
    ggvc_cmd_if  cmd ();

    go_to_goal_velocity_controller_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg.sink),
        .i_pose  (pose.sink),
        .o_cmd   (cmd.source)
    );

    always #5 i_clk = ~i_clk;

    // controller state as the predictor sees it
    logic signed [31:0] goal_x, goal_y;
    logic signed [14:0] goal_heading;
    logic [15:0]        turn_gain, speed_gain;
    logic [30:0]        distance_margin;
    logic [13:0]        heading_margin;
    logic               reached;

    t_cmd   expected_cmds[$];
    int     errors = 0;
    longint cycles = 0;
    bit     idle_en = 1'b1;
    int     stall_left = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // sink side: random stall bursts while idling is enabled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd.ready <= 1'b0;
        end else if (stall_left > 0) begin
            cmd.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            cmd.ready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            cmd.ready <= 1'b1;
        end
    end

    function automatic longint wrap_q12(longint d);
        longint m;
        m = d % 25736;
        if (m < 0) m += 25736;
        if (m > 12868) m -= 25736;
        return m;
    endfunction

    function automatic longint turn_from_err(longint err);
        return (longint'(turn_gain) * err + 8) >>> 4;
    endfunction

    // control law for one pose; updates the reached flag
    function automatic t_cmd steer_toward_goal(logic signed [31:0] rx, logic signed [31:0] ry,
                                               logic signed [14:0] rh);
        longint x, y, z, xs, ys, span, bearing, err, turn, speed;
        t_cmd c;
        x = longint'(goal_x) - longint'(rx);
        y = longint'(goal_y) - longint'(ry);
        z = 0;
        turn = 0;
        speed = 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(ggvc_pkg::PI_Q16) : -longint'(ggvc_pkg::PI_Q16);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ggvc_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(ggvc_pkg::ATAN_Q16[i]);
            end else begin
                x -= ys; y += xs; z -= longint'(ggvc_pkg::ATAN_Q16[i]);
            end
        end
        if (x < 0) x = 0;
        span = (x * longint'(ggvc_pkg::INV_GAIN_Q22) + (longint'(1) << 21)) >>> 22;
        bearing = (z + 8) >>> 4;
        if (span <= longint'(distance_margin)) begin
            err = wrap_q12(longint'(goal_heading) - longint'(rh));
            if ((err < 0 ? -err : err) <= longint'(heading_margin)) begin
                reached = 1'b1;
            end else begin
                turn = turn_from_err(err);
            end
        end else begin
            err = wrap_q12(bearing - longint'(rh));
            if ((err < 0 ? -err : err) <= 6434) begin
                turn = turn_from_err(err);
                if (turn > 65536) turn = 65536;
                else if (turn < -65536) turn = -65536;
                speed = (longint'(speed_gain) * span + 128) >>> 8;
                if (speed > 32768) speed = 32768;
            end else begin
                turn = (err > 0) ? 65536 : -65536;
            end
        end
        c.forward_speed = speed[15:0];
        c.turn_rate = turn[31:0];
        c.goal_done = reached;
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_cmd want;
        if (i_rst_n && cmd.valid && cmd.ready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                want = expected_cmds.pop_front();
                if (cmd.forward_speed !== want.forward_speed)
                    report_mismatch("forward_speed", cmd.forward_speed, want.forward_speed);
                if (cmd.turn_rate !== want.turn_rate)
                    report_mismatch("turn_rate", cmd.turn_rate, want.turn_rate);
                if (cmd.goal_done !== want.goal_done)
                    report_mismatch("goal_done", cmd.goal_done, want.goal_done);
            end
        end
    end

    // hold valid after the beat; the caller drops it once the writes are done
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            ggvc_pkg::REG_GOAL_X:          begin goal_x = value; reached = 1'b0; end
            ggvc_pkg::REG_GOAL_Y:          begin goal_y = value; reached = 1'b0; end
            ggvc_pkg::REG_GOAL_HEADING:    begin
                goal_heading = value[14:0];
                reached = 1'b0;
            end
            ggvc_pkg::REG_TURN_GAIN:       turn_gain = value[15:0];
            ggvc_pkg::REG_SPEED_GAIN:      speed_gain = value[15:0];
            ggvc_pkg::REG_DISTANCE_MARGIN: distance_margin = value[30:0];
            ggvc_pkg::REG_HEADING_MARGIN:  heading_margin = value[13:0];
            default: ;
        endcase
    endtask

    task automatic send_pose(logic [31:0] rx, logic [31:0] ry, logic [14:0] rh);
        int gap;
        t_cmd c;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            pose.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pose.valid <= 1'b1;
        pose.robot_x <= rx;
        pose.robot_y <= ry;
        pose.robot_heading <= rh;
        do @(posedge i_clk); while (!pose.ready);
        c = steer_toward_goal(rx, ry, rh);
        expected_cmds = {expected_cmds, c};
    endtask

    // drop valid, wait for every command, then let the pipeline settle
    task automatic drain();
        pose.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] gx, logic [31:0] gy, logic [31:0] gh,
                           logic [31:0] tg, logic [31:0] sg, logic [31:0] dm,
                           logic [31:0] hm);
        write_reg(ggvc_pkg::REG_GOAL_X, gx);
        write_reg(ggvc_pkg::REG_GOAL_Y, gy);
        write_reg(ggvc_pkg::REG_GOAL_HEADING, gh);
        write_reg(ggvc_pkg::REG_TURN_GAIN, tg);
        write_reg(ggvc_pkg::REG_SPEED_GAIN, sg);
        write_reg(ggvc_pkg::REG_DISTANCE_MARGIN, dm);
        write_reg(ggvc_pkg::REG_HEADING_MARGIN, hm);
        cfg.valid <= 1'b0;
    endtask

    task automatic test_directed();
        // reset defaults: goal at origin
        send_pose(0, 0, 0);
        send_pose(0, 0, 15'sd12868);
        send_pose(0, 0, -15'sd12868);
        send_pose(0, 0, 15'h3FFF);
        send_pose(0, 0, 15'h4000);
        send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_pose(32'h8000_0000, 32'h8000_0000, 0);
        send_pose(32'h8000_0000, 32'h7FFF_FFFF, 15'h3FFF);
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 15'h4000);
        // goal straight ahead, behind, and to each side
        send_pose(-32'sd200000, 0, 0);
        send_pose(32'sd200000, 0, 0);
        send_pose(32'sd200000, 32'sd1, 0);
        send_pose(32'sd200000, -32'sd1, 0);
        send_pose(0, -32'sd65536, 0);
        send_pose(0, 32'sd65536, 0);
        send_pose(-32'sd20000, -32'sd10000, 0);
        send_pose(-32'sd20000, 32'sd10000, 0);
        send_pose(-32'sd100, 0, 0);
        drain();
        // goal write clears the reached flag; unknown index and wide data
        write_reg(ggvc_pkg::REG_GOAL_HEADING, 32'hFFFF_8000 | 32'd1000);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        cfg.valid <= 1'b0;
        send_pose(0, 0, 15'sd1000);
        send_pose(0, 0, 0);
        drain();
        write_reg(ggvc_pkg::REG_TURN_GAIN, 32'hFFFF_0000);
        write_reg(ggvc_pkg::REG_HEADING_MARGIN, 32'hFFFF_C000);
        cfg.valid <= 1'b0;
        send_pose(0, 0, 15'sd1000);
        drain();
    endtask

    task automatic test_random_phase(int n);
        longint dm, ox, oy;
        int hm, kind;
        logic [14:0] h;
        dm = (distance_margin > 31'd268435455) ? 268435455 : longint'(distance_margin) + 1;
        hm = int'(heading_margin) + 1;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // close to the goal, heading near the goal heading
                ox = $urandom_range(0, 32'(2 * dm)) - dm;
                oy = $urandom_range(0, 32'(2 * dm)) - dm;
                h = 15'(longint'(goal_heading) + $urandom_range(0, 4 * hm) - 2 * hm);
            end else if (kind < 8) begin
                ox = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                oy = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                h = 15'($urandom_range(0, 32767));
            end else begin
                ox = $urandom();
                oy = $urandom();
                h = 15'($urandom_range(0, 32767));
            end
            send_pose(32'(longint'(goal_x) - ox), 32'(longint'(goal_y) - oy), h);
        end
        drain();
    endtask

    task automatic test_settings();
        set_all(32'sd150000, -32'sd90000, 32'sd3000, 256, 256, 6554, 410);
        test_random_phase(320);
        // zero gains and margins
        set_all($urandom(), $urandom(), 32'hFFFF_CDBC, 0, 0, 0, 0);
        test_random_phase(320);
        // largest gains and margins
        set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'd12868, 32'hFFFF, 32'hFFFF,
                32'h7FFF_FFFF, 32'd12868);
        test_random_phase(320);
        set_all($urandom(), $urandom(), $urandom_range(0, 32767), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 32'h0010_0000),
                $urandom_range(0, 16383));
        test_random_phase(320);
        set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_4000, 32'd4096, 32'd8,
                32'd65536, 32'h3FFF);
        test_random_phase(320);
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        set_all($urandom(), $urandom(), $urandom_range(0, 32767), $urandom_range(0, 2048),
                $urandom_range(0, 2048), $urandom_range(0, 200000), $urandom_range(0, 2000));
        test_random_phase(330);
    endtask

    initial begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        pose.valid = 1'b0;
        pose.robot_x = '0;
        pose.robot_y = '0;
        pose.robot_heading = '0;
        goal_x = 0;
        goal_y = 0;
        goal_heading = 0;
        turn_gain = 16'd256;
        speed_gain = 16'd256;
        distance_margin = 31'd6554;
        heading_margin = 14'd410;
        reached = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        test_full_rate();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
